// ===== src/timed_window_motor_control_defines.svh =====
// ----------------------------------------------------------------------------
// timed window motor control assertion macros
// shared concurrent assertion forms, clocked on clock, quiet during reset
// ----------------------------------------------------------------------------
`ifndef TIMED_WINDOW_MOTOR_CONTROL_DEFINES_SVH
`define TIMED_WINDOW_MOTOR_CONTROL_DEFINES_SVH

// same-cycle implication
`define TWMC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TWMC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/twmc_pkg.sv =====
// ----------------------------------------------------------------------------
// twmc_pkg
// types and widths shared by the timed window motor control block
// ----------------------------------------------------------------------------
`default_nettype none

package twmc_pkg;

   localparam int POS_W     = 32;
   localparam int ELAPSED_W = 16;
   localparam int REQ_DATA_W = 56;  // 49 field bits, padded to bytes
   localparam int RSP_DATA_W = 40;  // 37 field bits, padded to bytes

   localparam logic KIND_MOVE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   typedef struct packed {
      logic                 kind;
      logic                 direction;
      logic [POS_W-1:0]     target_position;
      logic [ELAPSED_W-1:0] elapsed;
   } item_type;

   typedef struct packed {
      logic             accepted;
      logic             relay_a;
      logic             relay_b;
      logic             busy_res;
      logic             opening;
      logic [POS_W-1:0] position;
   } result_type;

endpackage

`default_nettype wire

// ===== src/timed_window_motor_control.sv =====
// ----------------------------------------------------------------------------
// timed_window_motor_control
// run-time based window motor control through an open and a close relay
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            payload
//  req      in   req_tvalid/tready    tuser: kind; tdata: direction, target, elapsed
//  rsp      out  rsp_tvalid/tready    tdata: accepted, relays, busy, opening, position
//  csr      in   csr_wr_en            csr_wr_data: relay_on_level
//
//  one item per clock while rsp drains; rsp tvalid rises after the input and result registers
//  the state update sits between the input register and the result register
//  reset is synchronous: position zero, idle, relays off, on level zero
//  a stalled rsp holds the result and backs up req only once both registers fill
//
`default_nettype none

module timed_window_motor_control (
   input  wire                                 clock,
   input  wire                                 reset,
   // req
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [twmc_pkg::REQ_DATA_W-1:0]     req_tdata,  // direction, target_position, elapsed
   input  wire                                 req_tuser,  // kind
   // rsp
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [twmc_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // accepted, relay_a, relay_b,
                                                           // busy_res, opening, position
   // csr
   input  wire                                 csr_wr_en,
   input  wire                                 csr_wr_data  // relay_on_level
);
   import twmc_pkg::*;

   logic       level_ff;
   logic       in_valid_ff;
   item_type   in_item_ff;
   item_type   req_item;
   result_type step_result;
   logic       out_ready;
   logic       step_fire;

   // unpack the incoming item
   assign req_item.kind            = req_tuser;
   assign req_item.direction       = req_tdata[0];
   assign req_item.target_position = req_tdata[POS_W:1];
   assign req_item.elapsed         = req_tdata[POS_W + ELAPSED_W:POS_W + 1];

   // the held item is processed as it moves into the result register
   assign step_fire  = in_valid_ff && out_ready;
   assign req_tready = !in_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff    <= 1'b0;
         in_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            level_ff <= csr_wr_data;
         end
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
      end
   end

   // payload of the input register, no reset needed
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff <= req_item;
      end
   end

   twmc_step u_step (
      .clock    (clock),
      .reset    (reset),
      .step_en  (step_fire),
      .item     (in_item_ff),
      .on_level (level_ff),
      .result   (step_result)
   );

   twmc_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load_valid (in_valid_ff),
      .load_ready (out_ready),
      .result     (step_result),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== src/twmc_step.sv =====
// ----------------------------------------------------------------------------
// twmc_step
// motor state registers and the per-item update, one item per enabled cycle
// ----------------------------------------------------------------------------
`default_nettype none

`include "timed_window_motor_control_defines.svh"

module twmc_step (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    step_en,
   input  twmc_pkg::item_type     item,
   input  wire                    on_level,
   output twmc_pkg::result_type   result
);
   import twmc_pkg::*;

   logic [POS_W-1:0] position_ff, position_in;
   logic [POS_W-1:0] target_ff,   target_in;
   logic [POS_W-1:0] interval_ff, interval_in;
   logic [POS_W-1:0] count_ff,    count_in;
   logic             moving_ff,   moving_in;
   logic             open_ff,     open_in;
   logic             drive_a_ff,  drive_a_in;
   logic             drive_b_ff,  drive_b_in;

   logic             dir_ok;
   logic             accept;
   logic [POS_W:0]   sum;
   logic [POS_W-1:0] sat_count;

   always_comb begin
      position_in = position_ff;
      target_in   = target_ff;
      interval_in = interval_ff;
      count_in    = count_ff;
      moving_in   = moving_ff;
      open_in     = open_ff;
      drive_a_in  = drive_a_ff;
      drive_b_in  = drive_b_ff;

      dir_ok = item.direction ? (item.target_position > position_ff)
                              : (item.target_position < position_ff);
      accept = (item.kind == KIND_MOVE) && !moving_ff && dir_ok;

      sum       = {1'b0, count_ff} + {{(POS_W + 1 - ELAPSED_W){1'b0}}, item.elapsed};
      sat_count = sum[POS_W] ? {POS_W{1'b1}} : sum[POS_W-1:0];

      if (item.kind == KIND_MOVE) begin
         if (accept) begin
            interval_in = item.direction ? (item.target_position - position_ff)
                                         : (position_ff - item.target_position);
            count_in    = '0;
            target_in   = item.target_position;
            open_in     = item.direction;
            moving_in   = 1'b1;
         end
      end else if (!moving_ff) begin
         drive_a_in = 1'b0;
         drive_b_in = 1'b0;
      end else if (sat_count >= interval_ff) begin
         // move done: land on target, everything off
         position_in = target_ff;
         interval_in = '0;
         count_in    = '0;
         open_in     = 1'b0;
         moving_in   = 1'b0;
         drive_a_in  = 1'b0;
         drive_b_in  = 1'b0;
      end else begin
         count_in   = sat_count;
         drive_a_in = open_ff;
         drive_b_in = !open_ff;
      end

      result.accepted = accept;
      result.relay_a  = ~(drive_a_in ^ on_level);
      result.relay_b  = ~(drive_b_in ^ on_level);
      result.busy_res = moving_in;
      result.opening  = open_in;
      result.position = position_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         target_ff   <= '0;
         interval_ff <= '0;
         count_ff    <= '0;
         moving_ff   <= 1'b0;
         open_ff     <= 1'b0;
         drive_a_ff  <= 1'b0;
         drive_b_ff  <= 1'b0;
      end else if (step_en) begin
         position_ff <= position_in;
         target_ff   <= target_in;
         interval_ff <= interval_in;
         count_ff    <= count_in;
         moving_ff   <= moving_in;
         open_ff     <= open_in;
         drive_a_ff  <= drive_a_in;
         drive_b_ff  <= drive_b_in;
      end
   end

   `TWMC_ASSERT_NOW(a_idle_clear, !moving_ff, (interval_ff == '0) && (count_ff == '0) && !open_ff, "idle state not cleared")
   `TWMC_ASSERT_NOW(a_count_below, moving_ff, count_ff < interval_ff, "count reached interval while moving")
   `TWMC_ASSERT_NOW(a_single_relay, 1'b1, !(drive_a_ff && drive_b_ff), "both relays energized")
   `TWMC_ASSERT_NEXT(a_accept_moves, step_en && accept, moving_ff, "accepted move did not start")

endmodule

`default_nettype wire

// ===== src/twmc_out_reg.sv =====
// ----------------------------------------------------------------------------
// twmc_out_reg
// result register on the rsp channel, loads whenever empty or being drained
// ----------------------------------------------------------------------------
`default_nettype none

module twmc_out_reg (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 load_valid,
   output logic                                load_ready,
   input  twmc_pkg::result_type                result,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [twmc_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import twmc_pkg::*;

   logic       valid_ff;
   result_type data_ff;

   assign load_ready = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load_ready) begin
         valid_ff <= load_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load_ready && load_valid) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - POS_W - 5){1'b0}}, data_ff.position, data_ff.opening,
                        data_ff.busy_res, data_ff.relay_b, data_ff.relay_a, data_ff.accepted};

endmodule

`default_nettype wire
